// ----- rtl/core/stt_pkg.sv -----
// stt_pkg: shared types, token codes and keyword tables of the tokenizer
// no dependencies
`default_nettype none
package stt_pkg;

	localparam int OffsetBitsDef = 16;
	localparam int KwMaxLenDef   = 8;
	localparam int MaxTokens     = 4;

	// token kinds
	localparam logic [5:0] K_LPAREN   = 6'd0;
	localparam logic [5:0] K_RPAREN   = 6'd1;
	localparam logic [5:0] K_COMMA    = 6'd2;
	localparam logic [5:0] K_DOT      = 6'd3;
	localparam logic [5:0] K_MINUS    = 6'd4;
	localparam logic [5:0] K_PLUS     = 6'd5;
	localparam logic [5:0] K_STAR     = 6'd6;
	localparam logic [5:0] K_SLASH    = 6'd7;
	localparam logic [5:0] K_LBRACK   = 6'd8;
	localparam logic [5:0] K_RBRACK   = 6'd9;
	localparam logic [5:0] K_BANG     = 6'd10;
	localparam logic [5:0] K_EQ       = 6'd12;
	localparam logic [5:0] K_LT       = 6'd14;
	localparam logic [5:0] K_GT       = 6'd16;
	localparam logic [5:0] K_NEWLINE  = 6'd18;
	localparam logic [5:0] K_STRING   = 6'd19;
	localparam logic [5:0] K_NUMBER   = 6'd20;
	localparam logic [5:0] K_IDENT    = 6'd21;
	localparam logic [5:0] K_KW0      = 6'd22;
	localparam logic [5:0] K_END      = 6'd44;
	localparam logic [5:0] K_ERR_CHAR = 6'd45;
	localparam logic [5:0] K_ERR_STR  = 6'd46;

	localparam int NumKw = 22;

	// scan modes
	typedef enum logic [2:0] {
		M_IDLE    = 3'd0,
		M_OPER    = 3'd1,
		M_COMMENT = 3'd2,
		M_STRING  = 3'd3,
		M_INT     = 3'd4,
		M_DOT     = 3'd5,
		M_FRAC    = 3'd6,
		M_WORD    = 3'd7
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] source_byte;
		logic       byte_present;
		logic       end_of_source;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic [15:0] line_number;
		logic        last_of_run;
	} out_item_t;

	// keyword text, lower case, first byte in the low bits
	function automatic logic [63:0] kw_text(input int k);
		logic [63:0] t;
		t = '0;
		unique case (k)
			0:  t = {40'h0, "dna"};
			1:  t = {32'h0, "esle"};
			2:  t = {24'h0, "eslaf"};
			3:  t = {40'h0, "rof"};
			4:  t = "noitcnuf";
			5:  t = {48'h0, "fi"};
			6:  t = {40'h0, "lin"};
			7:  t = {48'h0, "ro"};
			8:  t = {24'h0, "tnirp"};
			9:  t = {8'h0, "nltnirp"};
			10: t = {24'h0, "tupni"};
			11: t = {16'h0, "nruter"};
			12: t = {32'h0, "eurt"};
			13: t = {24'h0, "elihw"};
			14: t = {48'h0, "od"};
			15: t = {40'h0, "dne"};
			16: t = {48'h0, "ot"};
			17: t = {32'h0, "neht"};
			18: t = {40'h0, "tel"};
			19: t = {24'h0, "kaerb"};
			20: t = {32'h0, "pool"};
			21: t = {16'h0, "taeper"};
			default: t = '0;
		endcase
		return t;
	endfunction

	function automatic int kw_len(input int k);
		int n;
		logic [63:0] t;
		t = kw_text(k);
		n = 0;
		for (int i = 0; i < 8; i++)
			if (t[i*8 +: 8] != 8'h0) n = i + 1;
		return n;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
	endfunction

	function automatic logic [5:0] op_base(input logic [7:0] p);
		logic [5:0] r;
		unique case (p)
			"=":     r = K_EQ;
			"<":     r = K_LT;
			">":     r = K_GT;
			default: r = K_BANG;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/stt_scan.sv -----
// stt_scan: front part, scans one byte per cycle, when in_fire is high, into up to four tokens
// depends on stt_pkg
`default_nettype none
module stt_scan #(
	parameter int OFFSET_BITS     = stt_pkg::OffsetBitsDef,
	parameter int KEYWORD_MAX_LEN = stt_pkg::KwMaxLenDef
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_fire,
	input  wire stt_pkg::in_item_t             in_item,
	output stt_pkg::out_item_t [stt_pkg::MaxTokens-1:0] toks,
	output logic [2:0]                         tok_count
);

	localparam int IdxW = $clog2(KEYWORD_MAX_LEN);
	localparam logic [OFFSET_BITS-1:0] OffMax = '1;

	stt_pkg::scan_mode_t       mode_q;
	logic [7:0]                pend_q;
	logic [OFFSET_BITS-1:0]    off_q;
	logic [OFFSET_BITS-1:0]    begin_q;
	logic [15:0]               line_q;
	logic [7:0]                wbuf_q [KEYWORD_MAX_LEN];
	logic [15:0]               wlen_q;

	stt_pkg::scan_mode_t       mode_d;
	logic [7:0]                pend_d;
	logic [OFFSET_BITS-1:0]    off_d;
	logic [OFFSET_BITS-1:0]    begin_d;
	logic [15:0]               line_d;
	logic [15:0]               wlen_d;
	logic                      wwr;
	logic [IdxW-1:0]           widx;
	logic [OFFSET_BITS-1:0]    pos, pos1;
	logic                      used;
	logic [7:0]                c;
	logic [5:0]                wkind;

	function automatic logic [15:0] cap16(input logic [OFFSET_BITS-1:0] v);
		logic [15:0] r;
		if (OFFSET_BITS > 16 && (v >> 16) != 0) r = 16'hFFFF;
		else r = 16'(v);
		return r;
	endfunction

	function automatic logic [OFFSET_BITS-1:0] inc(input logic [OFFSET_BITS-1:0] v);
		return (v == OffMax) ? v : v + 1'b1;
	endfunction

	// keyword compare over the buffered word
	always_comb begin
		logic lo, up;
		logic [63:0] t;
		wkind = stt_pkg::K_IDENT;
		for (int k = stt_pkg::NumKw - 1; k >= 0; k--) begin
			t = stt_pkg::kw_text(k);
			lo = (wlen_q == 16'(stt_pkg::kw_len(k)));
			up = lo;
			for (int i = 0; i < 8; i++) begin
				if (i < stt_pkg::kw_len(k) && i < KEYWORD_MAX_LEN) begin
					if (wbuf_q[i] != t[i*8 +: 8]) lo = 1'b0;
					if (wbuf_q[i] != t[i*8 +: 8] - 8'd32) up = 1'b0;
				end
			end
			if (lo || up) wkind = stt_pkg::K_KW0 + 6'(k);
		end
		if (wlen_q > 16'(KEYWORD_MAX_LEN)) wkind = stt_pkg::K_IDENT;
	end

	// keyword class of the word as it stands after this byte
	function automatic logic [5:0] wkind_end();
		logic lo, up;
		logic [63:0] t;
		logic [5:0] r;
		logic [15:0] l;
		logic [7:0] b;
		l = wlen_d;
		r = stt_pkg::K_IDENT;
		for (int k = stt_pkg::NumKw - 1; k >= 0; k--) begin
			t = stt_pkg::kw_text(k);
			lo = (l == 16'(stt_pkg::kw_len(k)));
			up = lo;
			for (int i = 0; i < 8; i++) begin
				if (i < stt_pkg::kw_len(k) && i < KEYWORD_MAX_LEN) begin
					b = (wwr && IdxW'(i) == widx) ? c : wbuf_q[i];
					if (b != t[i*8 +: 8]) lo = 1'b0;
					if (b != t[i*8 +: 8] - 8'd32) up = 1'b0;
				end
			end
			if (lo || up) r = stt_pkg::K_KW0 + 6'(k);
		end
		if (l > 16'(KEYWORD_MAX_LEN)) r = stt_pkg::K_IDENT;
		return r;
	endfunction

	// next state and token list
	always_comb begin
		logic [OFFSET_BITS-1:0] e, d;
		stt_pkg::scan_mode_t m;
		int n;
		mode_d = mode_q; pend_d = pend_q; off_d = off_q; begin_d = begin_q;
		line_d = line_q; wlen_d = wlen_q; wwr = 1'b0; widx = '0; used = 1'b1;
		c = in_item.source_byte;
		pos = off_q; pos1 = inc(off_q);
		n = 0;
		toks = '0;
		e = '0; d = '0; m = mode_q;
		for (int i = 0; i < stt_pkg::MaxTokens; i++) toks[i].line_number = line_q;

		if (in_item.byte_present) begin
			unique case (mode_q)
				stt_pkg::M_OPER: if (c == "=") begin
					toks[n].token_kind = stt_pkg::op_base(pend_q) + 6'd1;
					toks[n].token_start = cap16(begin_q);
					toks[n].token_length = cap16(pos1 > begin_q ? pos1 - begin_q : '0);
					n++; mode_d = stt_pkg::M_IDLE;
				end else used = 1'b0;
				stt_pkg::M_COMMENT: if (c == 8'h0A) begin
					mode_d = stt_pkg::M_IDLE; used = 1'b0;
				end
				stt_pkg::M_STRING: if (c == "\"") begin
					toks[n].token_kind = stt_pkg::K_STRING;
					toks[n].token_start = cap16(begin_q);
					toks[n].token_length = cap16(pos1 > begin_q ? pos1 - begin_q : '0);
					n++; mode_d = stt_pkg::M_IDLE;
				end else if (c == 8'h0A && line_q != 16'hFFFF) line_d = line_q + 16'd1;
				stt_pkg::M_INT: if (c == ".") mode_d = stt_pkg::M_DOT;
					else if (!stt_pkg::is_digit(c)) used = 1'b0;
				stt_pkg::M_DOT: if (stt_pkg::is_digit(c)) mode_d = stt_pkg::M_FRAC;
					else used = 1'b0;
				stt_pkg::M_FRAC: if (!stt_pkg::is_digit(c)) used = 1'b0;
				stt_pkg::M_WORD: if (stt_pkg::is_alpha(c) || stt_pkg::is_digit(c)) begin
					wwr = (wlen_q < 16'(KEYWORD_MAX_LEN));
					widx = IdxW'(wlen_q);
					if (wlen_q != 16'hFFFF) wlen_d = wlen_q + 16'd1;
				end else used = 1'b0;
				default: used = 1'b0;
			endcase
			if (!used) begin
				// close the open token at pos
				e = pos; m = mode_q;
				if (m == stt_pkg::M_OPER || m == stt_pkg::M_INT || m == stt_pkg::M_FRAC
					|| m == stt_pkg::M_WORD) begin
					toks[n].token_kind = (m == stt_pkg::M_OPER) ? stt_pkg::op_base(pend_q) :
						(m == stt_pkg::M_WORD) ? wkind : stt_pkg::K_NUMBER;
					toks[n].token_start = cap16(begin_q);
					toks[n].token_length = cap16(e > begin_q ? e - begin_q : '0);
					n++;
				end else if (m == stt_pkg::M_DOT) begin
					d = (e > begin_q) ? e - 1'b1 : begin_q;
					toks[n].token_kind = stt_pkg::K_NUMBER;
					toks[n].token_start = cap16(begin_q);
					toks[n].token_length = cap16(d > begin_q ? d - begin_q : '0);
					n++;
					toks[n].token_kind = stt_pkg::K_DOT;
					toks[n].token_start = cap16(d);
					toks[n].token_length = cap16(e > d ? e - d : '0);
					n++;
				end
				// scan the byte from idle
				mode_d = stt_pkg::M_IDLE;
				begin_d = pos;
				toks[n].token_start = cap16(pos);
				toks[n].token_length = cap16(pos1 > pos ? pos1 - pos : '0);
				priority case (c)
					"(": begin toks[n].token_kind = stt_pkg::K_LPAREN; n++; end
					")": begin toks[n].token_kind = stt_pkg::K_RPAREN; n++; end
					",": begin toks[n].token_kind = stt_pkg::K_COMMA; n++; end
					".": begin toks[n].token_kind = stt_pkg::K_DOT; n++; end
					"-": begin toks[n].token_kind = stt_pkg::K_MINUS; n++; end
					"+": begin toks[n].token_kind = stt_pkg::K_PLUS; n++; end
					"*": begin toks[n].token_kind = stt_pkg::K_STAR; n++; end
					"/": begin toks[n].token_kind = stt_pkg::K_SLASH; n++; end
					"[": begin toks[n].token_kind = stt_pkg::K_LBRACK; n++; end
					"]": begin toks[n].token_kind = stt_pkg::K_RBRACK; n++; end
					"!", "=", "<", ">": begin mode_d = stt_pkg::M_OPER; pend_d = c; end
					"#": mode_d = stt_pkg::M_COMMENT;
					" ", 8'h0D, 8'h09: ;
					8'h0A: begin
						toks[n].token_kind = stt_pkg::K_NEWLINE; n++;
						if (line_q != 16'hFFFF) line_d = line_q + 16'd1;
					end
					"\"": mode_d = stt_pkg::M_STRING;
					default: if (stt_pkg::is_digit(c)) mode_d = stt_pkg::M_INT;
						else if (stt_pkg::is_alpha(c)) begin
							mode_d = stt_pkg::M_WORD; wwr = 1'b1; widx = '0; wlen_d = 16'd1;
						end else begin
							toks[n].token_kind = stt_pkg::K_ERR_CHAR; n++;
						end
				endcase
			end
			off_d = pos1;
		end

		if (in_item.end_of_source) begin
			e = off_d; m = mode_d;
			toks[n].token_start = cap16(begin_d);
			toks[n].token_length = cap16(e > begin_d ? e - begin_d : '0);
			toks[n].line_number = line_d;
			if (m == stt_pkg::M_STRING) begin
				toks[n].token_kind = stt_pkg::K_ERR_STR; n++;
			end else if (m == stt_pkg::M_OPER || m == stt_pkg::M_INT
				|| m == stt_pkg::M_FRAC) begin
				toks[n].token_kind = (m == stt_pkg::M_OPER) ? stt_pkg::op_base(pend_d)
					: stt_pkg::K_NUMBER;
				n++;
			end else if (m == stt_pkg::M_WORD) begin
				// the word can only have been extended by this byte when it stays open
				toks[n].token_kind = wkind_end(); n++;
			end else if (m == stt_pkg::M_DOT) begin
				d = (e > begin_d) ? e - 1'b1 : begin_d;
				toks[n].token_kind = stt_pkg::K_NUMBER;
				toks[n].token_length = cap16(d > begin_d ? d - begin_d : '0);
				n++;
				toks[n].token_kind = stt_pkg::K_DOT;
				toks[n].token_start = cap16(d);
				toks[n].token_length = cap16(e > d ? e - d : '0);
				toks[n].line_number = line_d;
				n++;
			end
			toks[n].token_kind = stt_pkg::K_END;
			toks[n].token_start = cap16(e);
			toks[n].token_length = '0;
			toks[n].line_number = line_d;
			n++;
			mode_d = stt_pkg::M_IDLE; pend_d = '0; off_d = '0; begin_d = '0;
			line_d = 16'd1; wlen_d = '0;
		end
		tok_count = 3'(n);
		if (n > 0) toks[n-1].last_of_run = 1'b1;
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stt_pkg::M_IDLE; pend_q <= '0; off_q <= '0; begin_q <= '0;
			line_q <= 16'd1; wlen_q <= '0;
		end else if (in_fire) begin
			mode_q <= mode_d; pend_q <= pend_d; off_q <= off_d; begin_q <= begin_d;
			line_q <= line_d; wlen_q <= wlen_d;
		end
	end

	// word buffer
	always_ff @(posedge clk) begin
		if (in_fire && wwr)
			wbuf_q[widx] <= c;
	end

endmodule
`default_nettype wire

// ----- rtl/core/stt_queue.sv -----
// stt_queue: token queue between scanner and output, up to four in per cycle
// depends on stt_pkg
`default_nettype none
module stt_queue (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    push,
	input  wire logic [2:0]                              push_count,
	input  wire stt_pkg::out_item_t [stt_pkg::MaxTokens-1:0] push_items,
	output logic                                         has_room,
	output logic                                         out_valid,
	input  wire logic                                    out_ready,
	output stt_pkg::out_item_t                           out_item
);

	localparam int Depth = 8;
	localparam int AW = 3;

	stt_pkg::out_item_t mem_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          pop;
	logic [2:0]    nin;

	assign out_valid = (cnt_q != '0);
	assign out_item  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign nin       = push ? push_count : 3'd0;
	// room for a full burst of four
	assign has_room  = (cnt_q <= 4'(Depth - stt_pkg::MaxTokens));

	// storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < stt_pkg::MaxTokens; i++)
			if (push && 3'(i) < push_count) mem_q[wr_q + AW'(i)] <= push_items[i];
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(nin);
			rd_q  <= rd_q + AW'(pop);
			cnt_q <= cnt_q + 4'(nin) - 4'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q <= 4'(Depth - stt_pkg::MaxTokens))) else $error("queue overflow");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		!push && !pop |=> $stable(cnt_q)) else $error("count moved");
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'(Depth)) else $error("count too large");

endmodule
`default_nettype wire

// ----- rtl/core/source_text_tokenizer_core.sv -----
// a token reaches the output through the registered token queue
// throughput: one byte per cycle while the eight-entry token queue has room for four
// a stalled output fills the queue and then holds in_ready low
// reset: arst_n clears scanner state (line counter to one) and empties the queue
// depends on stt_pkg, stt_scan, stt_queue
`default_nettype none
module source_text_tokenizer_core #(
	parameter int OFFSET_BITS     = stt_pkg::OffsetBitsDef,
	parameter int KEYWORD_MAX_LEN = stt_pkg::KwMaxLenDef
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire stt_pkg::in_item_t in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output stt_pkg::out_item_t     out_data
);

	stt_pkg::out_item_t [stt_pkg::MaxTokens-1:0] toks;
	logic [2:0] cnt;
	logic       fire;

	assign fire = in_valid && in_ready;

	stt_scan #(.OFFSET_BITS(OFFSET_BITS), .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_scan (
		.clk, .arst_n, .in_fire(fire), .in_item(in_data), .toks, .tok_count(cnt));

	stt_queue u_queue (
		.clk, .arst_n, .push(fire), .push_count(cnt), .push_items(toks),
		.has_room(in_ready), .out_valid, .out_ready, .out_item(out_data));

endmodule
`default_nettype wire
